// ----- src/voice_stereo_widener_unit_macros.svh -----
// Assertion macros shared by the stereo widener checker.
// No dependencies; included by the checker file only.
`ifndef VOICE_STEREO_WIDENER_UNIT_MACROS_SVH
`define VOICE_STEREO_WIDENER_UNIT_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger
`define VSW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger
`define VSW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/vsw_pkg.sv -----
// Shared types and fixed-point constants of the voice stereo widener.
// No dependencies; used by the interfaces, the square root unit and the top level.
package vsw_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx CFG_WIDEN_ENABLE    = 2'd0;
    localparam t_cfg_idx CFG_AMOUNT_PERMILLE = 2'd1;
    localparam t_cfg_idx CFG_DELAY_SAMPLES   = 2'd2;

    localparam int PERMILLE_W = 10;
    localparam int DELAY_W    = 11;

    localparam logic [PERMILLE_W-1:0] PERMILLE_RESET = 10'd500;
    localparam logic [PERMILLE_W-1:0] PERMILLE_MAX   = 10'd1000;
    localparam logic [DELAY_W-1:0]    DELAY_RESET    = 11'd864;

    // Amount in Q0.16
    localparam int AMT_W = 16;
    typedef logic [AMT_W-1:0] t_amount;
    localparam t_amount AMT_MAX      = 16'hFFFF;
    localparam t_amount BYPASS_BELOW = 16'd7;

    // Target = round(p * 65536 / 1000) = floor((p * 8192 + 62) / 125)
    localparam int TGT_NUM_W  = 23;
    localparam int TGT_PROD_W = 47;
    localparam int TGT_Q_W    = 17;
    localparam int TGT_SHIFT  = 30;
    localparam logic [TGT_NUM_W-1:0] TGT_BIAS  = 23'd62;
    localparam logic [23:0]          TGT_RECIP = 24'd8589935;

    // Slew step = floor(|diff| / 960) = floor(floor(|diff| / 64) / 15)
    localparam int SLEW_PRE_SHIFT = 6;
    localparam int SLEW_HI_W      = AMT_W - SLEW_PRE_SHIFT;
    localparam int SLEW_PROD_W    = 23;
    localparam int SLEW_SHIFT     = 16;
    localparam int SLEW_Q_W       = 7;
    localparam logic [12:0] SLEW_RECIP = 13'd4370;

    // Square root of 2^32 - a^2
    localparam int RAD_W  = 33;
    localparam int ROOT_W = 17;
    localparam logic [RAD_W-1:0]  RAD_ONE  = 33'h1_0000_0000;
    localparam logic [ROOT_W-1:0] Q16_ONE  = 17'h1_0000;

    // Q16 rounding
    localparam int Q_SHIFT = 16;
    localparam logic [15:0] ROUND_HALF = 16'h8000;

endpackage

// ----- src/vsw_if.sv -----
// Handshake channels of the voice stereo widener: frame input, result output
// and configuration writes. Depends on vsw_pkg.
interface vsw_in_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] voice_sample;
    logic signed [SAMPLE_WIDTH-1:0] left_in;
    logic signed [SAMPLE_WIDTH-1:0] right_in;
    logic                           block_first;

    modport source (output valid, voice_sample, left_in, right_in, block_first, input ready);
    modport sink   (input valid, voice_sample, left_in, right_in, block_first, output ready);
endinterface

interface vsw_out_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] left_out;
    logic signed [SAMPLE_WIDTH-1:0] right_out;

    modport source (output valid, left_out, right_out, input ready);
    modport sink   (input valid, left_out, right_out, output ready);
endinterface

interface vsw_cfg_if;
    logic                 valid;
    logic                 ready;
    vsw_pkg::t_cfg_idx    index;
    vsw_pkg::t_cfg_data   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/vsw_isqrt.sv -----
// Iterative integer square root, one result bit per cycle.
// Depends on vsw_pkg for operand widths.
module vsw_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [vsw_pkg::RAD_W-1:0]   i_radicand,
    output logic                        o_done,
    output logic [vsw_pkg::ROOT_W-1:0]  o_root
);
    localparam int RW = vsw_pkg::RAD_W;

    logic          r_busy;
    logic          r_done;
    logic [RW-1:0] r_x;
    logic [RW:0]   r_res;
    logic [RW-1:0] r_bit;

    logic [RW:0]   trial;
    logic          fits;

    // Trial subtract of the current bit
    always_comb begin
        trial = r_res + {1'b0, r_bit};
        fits  = ({1'b0, r_x} >= trial);
    end

    // Load on start, then shift the bit down two places per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_radicand;
                r_res  <= '0;
                r_bit  <= vsw_pkg::RAD_ONE;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (fits) begin
                    r_x   <= r_x - trial[RW-1:0];
                    r_res <= (r_res >> 1) + {1'b0, r_bit};
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit == RW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[vsw_pkg::ROOT_W-1:0];

endmodule

// ----- src/voice_stereo_widener_unit.sv -----
// Voice stereo widener: injects a mono voice sample into a stereo master pair
// as left + (c-1)*voice + a*delayed and right + (c-1)*voice - a*delayed with
// c = sqrt(1 - a^2), the side amount a slewing one step per frame toward its
// target. The delayed copy comes from a RING_DEPTH-entry ring in one
// synchronous memory; entries never written read as zero through a fill
// mark, so there is no clearing pass after reset. One frame is worked at a
// time: a widened frame runs through target, decision, slew, amount, square,
// the bit-serial square root, dry, side, sum and output; a bypassed frame
// skips from decision to output. The next frame can transfer in the cycle
// after the result is loaded, and is taken while a result waits in the
// output register. Depends on vsw_pkg, vsw_if and vsw_isqrt.
module voice_stereo_widener_unit #(
    parameter int RING_DEPTH   = 2048,
    parameter int BLOCK_FRAMES = 96,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vsw_in_if.sink     i_in,
    vsw_out_if.source  o_out,
    vsw_cfg_if.sink    i_cfg
);
    localparam int SW   = SAMPLE_WIDTH;
    localparam int AW   = $clog2(RING_DEPTH);
    localparam int DW   = vsw_pkg::DELAY_W;
    localparam int CW   = (AW > DW) ? AW : DW;
    localparam int DMAX = (RING_DEPTH > BLOCK_FRAMES + 1) ? RING_DEPTH - BLOCK_FRAMES : 1;
    localparam int AMW  = vsw_pkg::AMT_W;
    localparam int QS   = vsw_pkg::Q_SHIFT;

    localparam logic signed [SW+2:0] SAT_HI = (SW+3)'((64'd1 << (SW - 1)) - 64'd1);
    localparam logic signed [SW+2:0] SAT_LO = -SAT_HI - (SW+3)'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_TGT, S_DEC, S_SLEW, S_AMT, S_SQ, S_RSTART, S_RWAIT,
        S_DRY, S_SIDE, S_SUM, S_OUT
    } t_state;

    // Control registers
    t_state                              r_state;
    logic                                r_widen_enable;
    logic [vsw_pkg::PERMILLE_W-1:0]      r_amount_permille;
    logic [DW-1:0]                       r_delay_samples;
    logic                                r_bypassed;
    vsw_pkg::t_amount                    r_amount;
    logic [AW-1:0]                       r_wp;
    logic                                r_wrapped;
    logic                                r_out_valid;

    // Frame payload registers
    logic signed [SW-1:0]                r_voice;
    logic signed [SW-1:0]                r_left;
    logic signed [SW-1:0]                r_right;
    logic                                r_first;
    logic [vsw_pkg::TGT_Q_W-1:0]         r_tgt_q;
    vsw_pkg::t_amount                    r_target;
    logic                                r_rd_ok;
    logic signed [SW-1:0]                r_vd;
    logic [vsw_pkg::SLEW_Q_W-1:0]        r_q;
    logic                                r_dir_neg;
    logic                                r_move;
    logic [vsw_pkg::RAD_W-1:0]           r_rad;
    logic [vsw_pkg::ROOT_W-1:0]          r_root;
    logic signed [SW+1:0]                r_dry;
    logic signed [SW:0]                  r_side;
    logic signed [SW-1:0]                r_lo;
    logic signed [SW-1:0]                r_ro;
    logic signed [SW-1:0]                r_out_left;
    logic signed [SW-1:0]                r_out_right;

    // Ring memory
    logic signed [SW-1:0]                ring [RING_DEPTH];
    logic signed [SW-1:0]                r_ram_q;

    // Combinational datapath
    logic [vsw_pkg::PERMILLE_W-1:0]      p_sat;
    logic [vsw_pkg::TGT_NUM_W-1:0]       tgt_num;
    logic [vsw_pkg::TGT_PROD_W-1:0]      tgt_prod;
    vsw_pkg::t_amount                    tgt_sat;
    logic                                byp;
    logic [CW-1:0]                       dly_ext;
    logic [CW-1:0]                       dly_c;
    logic [AW-1:0]                       dly_a;
    logic [AW-1:0]                       rp;
    logic [AW-1:0]                       wp_next;
    logic                                wp_last;
    logic                                mem_we;
    logic signed [AMW:0]                 diff;
    logic [AMW:0]                        abs_diff;
    logic [vsw_pkg::SLEW_PROD_W-1:0]     q_prod;
    logic [vsw_pkg::SLEW_Q_W-1:0]        q_mag;
    logic [2*AMW-1:0]                    a_sq;
    logic signed [vsw_pkg::ROOT_W:0]     cm1;
    logic signed [SW+17:0]               dry_rnd;
    logic signed [SW+16:0]               side_rnd;
    logic signed [SW+2:0]                sum_l;
    logic signed [SW+2:0]                sum_r;
    logic signed [SW+2:0]                sat_l;
    logic signed [SW+2:0]                sat_r;
    logic                                sqrt_start;
    logic                                sqrt_done;
    logic [vsw_pkg::ROOT_W-1:0]          sqrt_root;

    // Target amount from the registers
    always_comb begin
        p_sat    = (r_amount_permille > vsw_pkg::PERMILLE_MAX) ? vsw_pkg::PERMILLE_MAX
                                                                : r_amount_permille;
        tgt_num  = {p_sat, 13'd0} + vsw_pkg::TGT_BIAS;
        tgt_prod = vsw_pkg::TGT_PROD_W'(tgt_num) * vsw_pkg::TGT_PROD_W'(vsw_pkg::TGT_RECIP);
        if (!r_widen_enable)
            tgt_sat = '0;
        else if (r_tgt_q > {1'b0, vsw_pkg::AMT_MAX})
            tgt_sat = vsw_pkg::AMT_MAX;
        else
            tgt_sat = r_tgt_q[AMW-1:0];
    end

    // Bypass decision, delay clamp and ring addresses
    always_comb begin
        if (r_first)
            byp = (r_target == '0) && (r_amount < vsw_pkg::BYPASS_BELOW);
        else
            byp = r_bypassed;
        dly_ext = CW'(r_delay_samples);
        if (dly_ext == '0)
            dly_c = CW'(1);
        else if (dly_ext > CW'(DMAX))
            dly_c = CW'(DMAX);
        else
            dly_c = dly_ext;
        dly_a = dly_c[AW-1:0];
        if (r_wp >= dly_a)
            rp = r_wp - dly_a;
        else
            rp = AW'({1'b0, r_wp} + (AW+1)'(RING_DEPTH) - {1'b0, dly_a});
        wp_last = (r_wp == AW'(RING_DEPTH - 1));
        wp_next = wp_last ? '0 : r_wp + AW'(1);
        mem_we  = (r_state == S_DEC) && !byp;
    end

    // Slew step magnitude and square of the amount
    always_comb begin
        diff     = $signed({1'b0, r_target}) - $signed({1'b0, r_amount});
        abs_diff = diff[AMW] ? (AMW+1)'(-diff) : (AMW+1)'(diff);
        q_prod   = vsw_pkg::SLEW_PROD_W'(abs_diff[AMW-1:vsw_pkg::SLEW_PRE_SHIFT])
                 * vsw_pkg::SLEW_PROD_W'(vsw_pkg::SLEW_RECIP);
        q_mag    = (r_q == '0) ? vsw_pkg::SLEW_Q_W'(1) : r_q;
        a_sq     = (2*AMW)'(r_amount) * (2*AMW)'(r_amount);
    end

    // Dry correction, side product and saturated sums
    always_comb begin
        cm1      = $signed({1'b0, r_root}) - $signed({1'b0, vsw_pkg::Q16_ONE});
        dry_rnd  = (SW+18)'(cm1) * (SW+18)'(r_voice)
                 + $signed((SW+18)'(vsw_pkg::ROUND_HALF));
        side_rnd = (SW+17)'($signed({1'b0, r_amount})) * (SW+17)'(r_vd)
                 + $signed((SW+17)'(vsw_pkg::ROUND_HALF));
        sum_l    = (SW+3)'(r_left) + (SW+3)'(r_dry) + (SW+3)'(r_side);
        sum_r    = (SW+3)'(r_right) + (SW+3)'(r_dry) - (SW+3)'(r_side);
        sat_l    = (sum_l > SAT_HI) ? SAT_HI : ((sum_l < SAT_LO) ? SAT_LO : sum_l);
        sat_r    = (sum_r > SAT_HI) ? SAT_HI : ((sum_r < SAT_LO) ? SAT_LO : sum_r);
        sqrt_start = (r_state == S_RSTART);
    end

    // Ring write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            ring[r_wp] <= r_voice;
            r_ram_q    <= ring[rp];
        end
    end

    // Sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_widen_enable    <= 1'b0;
            r_amount_permille <= vsw_pkg::PERMILLE_RESET;
            r_delay_samples   <= vsw_pkg::DELAY_RESET;
            r_bypassed        <= 1'b1;
            r_amount          <= '0;
            r_wp              <= '0;
            r_wrapped         <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            // Register writes
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    vsw_pkg::CFG_WIDEN_ENABLE:    r_widen_enable    <= i_cfg.data[0];
                    vsw_pkg::CFG_AMOUNT_PERMILLE:
                        r_amount_permille <= i_cfg.data[vsw_pkg::PERMILLE_W-1:0];
                    vsw_pkg::CFG_DELAY_SAMPLES:   r_delay_samples   <= i_cfg.data[DW-1:0];
                    default: ;
                endcase
            end

            // Drop the result once transferred; the output state reloads it itself
            if (o_out.ready && (r_state != S_OUT))
                r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_voice <= i_in.voice_sample;
                        r_left  <= i_in.left_in;
                        r_right <= i_in.right_in;
                        r_first <= i_in.block_first;
                        r_tgt_q <= tgt_prod[vsw_pkg::TGT_SHIFT +: vsw_pkg::TGT_Q_W];
                        r_state <= S_TGT;
                    end
                end
                S_TGT: begin
                    r_target <= tgt_sat;
                    r_state  <= S_DEC;
                end
                S_DEC: begin
                    if (r_first) begin
                        r_bypassed <= byp;
                        if (byp)
                            r_amount <= '0;
                    end
                    if (byp) begin
                        r_lo    <= r_left;
                        r_ro    <= r_right;
                        r_state <= S_OUT;
                    end else begin
                        r_rd_ok   <= r_wrapped || (rp < r_wp);
                        r_wp      <= wp_next;
                        r_wrapped <= r_wrapped || wp_last;
                        r_state   <= S_SLEW;
                    end
                end
                S_SLEW: begin
                    r_vd      <= r_rd_ok ? r_ram_q : '0;
                    r_q       <= q_prod[vsw_pkg::SLEW_SHIFT +: vsw_pkg::SLEW_Q_W];
                    r_dir_neg <= diff[AMW];
                    r_move    <= (diff != '0);
                    r_state   <= S_AMT;
                end
                S_AMT: begin
                    if (r_move) begin
                        if (r_dir_neg)
                            r_amount <= r_amount - AMW'(q_mag);
                        else
                            r_amount <= r_amount + AMW'(q_mag);
                    end
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_rad   <= vsw_pkg::RAD_ONE - {1'b0, a_sq};
                    r_state <= S_RSTART;
                end
                S_RSTART: begin
                    r_state <= S_RWAIT;
                end
                S_RWAIT: begin
                    if (sqrt_done) begin
                        r_root  <= sqrt_root;
                        r_state <= S_DRY;
                    end
                end
                S_DRY: begin
                    r_dry   <= dry_rnd[SW+17:QS];
                    r_state <= S_SIDE;
                end
                S_SIDE: begin
                    r_side  <= side_rnd[SW+16:QS];
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_lo    <= sat_l[SW-1:0];
                    r_ro    <= sat_r[SW-1:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Hold until the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_left  <= r_lo;
                        r_out_right <= r_ro;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    vsw_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (r_rad),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    assign i_in.ready      = (r_state == S_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_out.valid     = r_out_valid;
    assign o_out.left_out  = r_out_left;
    assign o_out.right_out = r_out_right;

endmodule

// ----- src/vsw_checker.sv -----
// Port-level checks for the voice stereo widener, bound to the top level.
// Depends on voice_stereo_widener_unit_macros.svh.
`include "voice_stereo_widener_unit_macros.svh"

module vsw_checker #(
    parameter int SAMPLE_WIDTH = 24
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [SAMPLE_WIDTH-1:0] i_out_left,
    input logic [SAMPLE_WIDTH-1:0] i_out_right
);
    logic       in_xfer;
    logic       out_xfer;
    logic [1:0] r_pending;

    assign in_xfer  = i_in_valid && i_in_ready;
    assign out_xfer = i_out_valid && i_out_ready;

    // Count frames taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_xfer && !out_xfer) begin
            r_pending <= r_pending + 2'd1;
        end else if (out_xfer && !in_xfer) begin
            r_pending <= r_pending - 2'd1;
        end
    end

    `VSW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_left) && $stable(i_out_right), "result changed while stalled")
    `VSW_ASSERT_NEXT(a_one_frame, i_clk, i_rst_n, in_xfer, !i_in_ready, "second frame taken while one is at work")
    `VSW_ASSERT_NOW(a_no_extra, i_clk, i_rst_n, i_out_valid, r_pending != 2'd0, "result shown with no frame pending")
    `VSW_ASSERT_NOW(a_depth, i_clk, i_rst_n, in_xfer, r_pending == 2'd0 || r_pending == 2'd1, "more than two frames pending")

endmodule

bind voice_stereo_widener_unit vsw_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_vsw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_left  (o_out.left_out),
    .i_out_right (o_out.right_out)
);

// ----- sim/voice_stereo_widener_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for voice_stereo_widener_unit: directed and random frames,
// register settings changed between phases, results checked against a local predictor.
// Depends on vsw_pkg, the vsw_if interfaces and the RTL of the widener.
module voice_stereo_widener_unit_tb;

    localparam int RING_DEPTH   = 2048;
    localparam int BLOCK_FRAMES = 96;
    localparam int SAMPLE_WIDTH = 24;
    localparam int SLEW_DIVISOR = 960;
    localparam int DELAY_LIMIT  = RING_DEPTH - BLOCK_FRAMES;
    localparam int MAX_GAP      = 64;
    localparam int DRAIN_LIMIT  = 100000;
    localparam int TAIL_CYCLES  = 40;
    localparam int PRINT_LIMIT  = 40;

    // Index that maps to no register
    localparam vsw_pkg::t_cfg_idx CFG_UNMAPPED = 2'd3;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef struct packed {
        t_sample left;
        t_sample right;
    } t_stereo_pair;

    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // Predicts the stereo pair of each frame and checks the pairs that come out
    class widener_scoreboard;
        t_sample                        delay_ring [RING_DEPTH];
        int                             write_pos;
        vsw_pkg::t_amount               amount;
        bit                             bypassed;
        bit                             widen_on;
        logic [vsw_pkg::PERMILLE_W-1:0] permille;
        logic [vsw_pkg::DELAY_W-1:0]    delay_len;
        t_stereo_pair                   expected_pairs [$];
        int                             error_count;
        int                             result_count;

        function new();
            foreach (delay_ring[i]) delay_ring[i] = '0;
            write_pos    = 0;
            amount       = '0;
            bypassed     = 1'b1;
            widen_on     = 1'b0;
            permille     = vsw_pkg::PERMILLE_RESET;
            delay_len    = vsw_pkg::DELAY_RESET;
            error_count  = 0;
            result_count = 0;
        endfunction

        task report(string msg);
            if (error_count < PRINT_LIMIT) $display("ERROR: %s", msg);
            error_count++;
        endtask

        function void write_register(vsw_pkg::t_cfg_idx idx, vsw_pkg::t_cfg_data data);
            case (idx)
                vsw_pkg::CFG_WIDEN_ENABLE:    widen_on  = data[0];
                vsw_pkg::CFG_AMOUNT_PERMILLE: permille  = data[vsw_pkg::PERMILLE_W-1:0];
                vsw_pkg::CFG_DELAY_SAMPLES:   delay_len = data[vsw_pkg::DELAY_W-1:0];
                default: ;
            endcase
        endfunction

        // Target side amount in Q0.16, saturated at the largest code
        function int target_q16();
            int p;
            int t;
            if (!widen_on) return 0;
            p = (permille > vsw_pkg::PERMILLE_MAX) ? int'(vsw_pkg::PERMILLE_MAX)
                                                   : int'(permille);
            t = (p * 65536 + 500) / 1000;
            return (t > int'(vsw_pkg::AMT_MAX)) ? int'(vsw_pkg::AMT_MAX) : t;
        endfunction

        // Floor of the square root, found bit by bit from the top
        function longint root_floor(longint x);
            longint r;
            longint t;
            r = 0;
            for (int b = 16; b >= 0; b--) begin
                t = r | (longint'(1) << b);
                if (t * t <= x) r = t;
            end
            return r;
        endfunction

        function longint round_q16(longint x);
            return (x + 32768) >>> 16;
        endfunction

        function longint clip(longint x);
            if (x > longint'(SAMPLE_MAX)) return longint'(SAMPLE_MAX);
            if (x < longint'(SAMPLE_MIN)) return longint'(SAMPLE_MIN);
            return x;
        endfunction

        function void note_frame(t_sample voice, t_sample left, t_sample right, bit first);
            int           tgt;
            int           diff;
            int           step;
            int           dly;
            int           rd_pos;
            longint       a;
            longint       c;
            longint       delayed;
            longint       dry;
            longint       side;
            longint       lo;
            longint       ro;
            t_stereo_pair pair;
            tgt = target_q16();
            // Decide bypass on the first frame of a block only
            if (first) begin
                bypassed = (tgt == 0) && (amount < vsw_pkg::BYPASS_BELOW);
                if (bypassed) amount = '0;
            end
            lo = longint'(left);
            ro = longint'(right);
            if (!bypassed) begin
                dly = int'(delay_len);
                if (dly < 1) dly = 1;
                if (dly > DELAY_LIMIT) dly = DELAY_LIMIT;
                // Write the voice, then read the copy from dly frames back
                delay_ring[write_pos] = voice;
                rd_pos  = (write_pos >= dly) ? write_pos - dly : write_pos + RING_DEPTH - dly;
                delayed = longint'(delay_ring[rd_pos]);
                write_pos = (write_pos + 1) % RING_DEPTH;
                // Slew one step toward the target, at least one code
                diff = tgt - int'(amount);
                step = diff / SLEW_DIVISOR;
                if (step == 0 && diff != 0) step = (diff > 0) ? 1 : -1;
                amount = vsw_pkg::t_amount'(int'(amount) + step);
                a    = longint'(amount);
                c    = root_floor((longint'(1) << 32) - a * a);
                dry  = round_q16((c - 65536) * longint'(voice));
                side = round_q16(a * delayed);
                lo   = clip(longint'(left) + dry + side);
                ro   = clip(longint'(right) + dry - side);
            end
            pair.left  = t_sample'(lo);
            pair.right = t_sample'(ro);
            expected_pairs.push_back(pair);
        endfunction

        task check_pair(t_sample left, t_sample right);
            t_stereo_pair want;
            if (expected_pairs.size() == 0) begin
                report($sformatf("result %0d arrived with no frame pending", result_count));
            end else begin
                want = expected_pairs.pop_front();
                if (left !== want.left)
                    report($sformatf("result %0d left_out %0d, predicted %0d",
                                     result_count, left, want.left));
                if (right !== want.right)
                    report($sformatf("result %0d right_out %0d, predicted %0d",
                                     result_count, right, want.right));
            end
            result_count++;
        endtask

        function int pending();
            return expected_pairs.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;

    widener_scoreboard stereo_check;

    vsw_in_if  #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) frame_if ();
    vsw_out_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) result_if ();
    vsw_cfg_if                                cfg_if ();

    voice_stereo_widener_unit #(
        .RING_DEPTH   (RING_DEPTH),
        .BLOCK_FRAMES (BLOCK_FRAMES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (frame_if),
        .o_out   (result_if),
        .i_cfg   (cfg_if)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready)
            stereo_check.check_pair(result_if.left_out, result_if.right_out);
    end

    function automatic t_sample random_sample();
        case ($urandom_range(9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return t_sample'(int'($urandom_range(511)) - 256);
            default: return t_sample'($urandom());
        endcase
    endfunction

    function automatic vsw_pkg::t_cfg_data random_delay();
        case ($urandom_range(7))
            0:       return vsw_pkg::t_cfg_data'(0);
            1:       return vsw_pkg::t_cfg_data'(1);
            2:       return vsw_pkg::t_cfg_data'(DELAY_LIMIT);
            3:       return vsw_pkg::t_cfg_data'(DELAY_LIMIT + 1);
            4:       return vsw_pkg::t_cfg_data'(2047);
            5:       return vsw_pkg::t_cfg_data'($urandom_range(100, 1));
            default: return vsw_pkg::t_cfg_data'($urandom_range(2047, 1));
        endcase
    endfunction

    // Idle a random number of cycles, then hold the frame until its transfer
    task automatic send_frame(t_sample voice, t_sample left, t_sample right, bit first);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            frame_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        frame_if.valid        <= 1'b1;
        frame_if.voice_sample <= voice;
        frame_if.left_in      <= left;
        frame_if.right_in     <= right;
        frame_if.block_first  <= first;
        do @(posedge i_clk); while (!frame_if.ready);
        stereo_check.note_frame(voice, left, right, first);
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        while (stereo_check.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    task automatic write_register(vsw_pkg::t_cfg_idx idx, vsw_pkg::t_cfg_data data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        stereo_check.write_register(idx, data);
    endtask

    // Drop frame valid, let the block drain, then write every register
    task automatic apply_settings(bit en, vsw_pkg::t_cfg_data perm, vsw_pkg::t_cfg_data dly);
        frame_if.valid <= 1'b0;
        wait_drained();
        write_register(CFG_UNMAPPED, vsw_pkg::t_cfg_data'($urandom()));
        write_register(vsw_pkg::CFG_WIDEN_ENABLE,
                       vsw_pkg::t_cfg_data'(($urandom() & 32'h7FE) | en));
        write_register(vsw_pkg::CFG_AMOUNT_PERMILLE, perm);
        write_register(vsw_pkg::CFG_DELAY_SAMPLES, dly);
        cfg_if.valid <= 1'b0;
    endtask

    // Mostly whole blocks led by block_first; some blocks of random length and stray markers
    task automatic run_blocks(int blocks);
        int len;
        bit first;
        for (int b = 0; b < blocks; b++) begin
            len = ($urandom_range(9) == 0) ? int'($urandom_range(120, 1)) : BLOCK_FRAMES;
            for (int f = 0; f < len; f++) begin
                if (f == 0) first = ($urandom_range(19) != 0);
                else        first = ($urandom_range(99) < 3);
                send_frame(random_sample(), random_sample(), random_sample(), first);
            end
        end
    endtask

    initial begin
        stereo_check = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n               = 1'b0;
        frame_if.valid        = 1'b0;
        frame_if.voice_sample = '0;
        frame_if.left_in      = '0;
        frame_if.right_in     = '0;
        frame_if.block_first  = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = '0;
        cfg_if.data           = '0;
        result_if.ready       = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset state bypasses: outputs follow inputs, bypass holds within the block
        send_frame(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, 1'b1);
        send_frame(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        send_frame(random_sample(), random_sample(), random_sample(), 1'b1);

        // Amount above full scale saturates, delay of zero clamps to one
        apply_settings(1'b1, vsw_pkg::t_cfg_data'(1023), vsw_pkg::t_cfg_data'(0));
        for (int k = 0; k < 2; k++)
            send_frame((k % 2) ? SAMPLE_MIN : SAMPLE_MAX, (k % 2) ? SAMPLE_MIN : SAMPLE_MAX,
                       (k % 2) ? SAMPLE_MAX : SAMPLE_MIN, k == 0);

        // Top delay clamps to ring minus block
        apply_settings(1'b1, vsw_pkg::t_cfg_data'(vsw_pkg::PERMILLE_MAX),
                       vsw_pkg::t_cfg_data'(2047));
        send_frame(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        send_frame(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b0);
        send_frame(random_sample(), random_sample(), random_sample(), 1'b0);

        // Zero target while the amount is still up: no bypass, amount fades
        apply_settings(1'b0, vsw_pkg::t_cfg_data'(vsw_pkg::PERMILLE_RESET),
                       vsw_pkg::t_cfg_data'(vsw_pkg::DELAY_RESET));
        send_frame(random_sample(), SAMPLE_MAX, SAMPLE_MIN, 1'b1);
        send_frame(random_sample(), random_sample(), random_sample(), 1'b0);
        send_frame(random_sample(), random_sample(), random_sample(), 1'b1);

        // Random phases, each with its own idle pattern
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 12;
                    recv_idle_pct = 88;
                end
                1: begin
                    send_idle_pct = 88;
                    recv_idle_pct = 12;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase < 2) begin
                // Small target, then fade to zero so bypass is taken again
                apply_settings(1'b1, vsw_pkg::t_cfg_data'($urandom_range(3, 1)),
                               random_delay());
                run_blocks(1);
                if ($urandom_range(1))
                    apply_settings(1'b0, vsw_pkg::t_cfg_data'($urandom()), random_delay());
                else
                    apply_settings(1'b1,
                                   vsw_pkg::t_cfg_data'($urandom_range(1) << vsw_pkg::PERMILLE_W),
                                   random_delay());
                run_blocks(3);
                apply_settings(1'($urandom_range(1)), vsw_pkg::t_cfg_data'($urandom_range(15)),
                               random_delay());
                run_blocks(2);
            end else begin
                // Large side amounts drive the sums into saturation
                apply_settings(1'b1,
                               $urandom_range(1) ? vsw_pkg::t_cfg_data'(vsw_pkg::PERMILLE_MAX)
                                                 : vsw_pkg::t_cfg_data'($urandom_range(1023, 900)),
                               random_delay());
                run_blocks(2);
                apply_settings(1'($urandom_range(1)), vsw_pkg::t_cfg_data'($urandom()),
                               random_delay());
                run_blocks(2);
                apply_settings(1'b0, vsw_pkg::t_cfg_data'($urandom()), random_delay());
                run_blocks(3);
            end
        end

        frame_if.valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (stereo_check.pending() != 0)
            stereo_check.report($sformatf("%0d predicted results never arrived",
                                          stereo_check.pending()));
        if (stereo_check.error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Hard stop far beyond the slowest correct run
    initial begin
        #30_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/vsw_pkg.sv
src/vsw_if.sv
src/vsw_isqrt.sv
src/voice_stereo_widener_unit.sv
src/vsw_checker.sv
sim/voice_stereo_widener_unit_tb.sv
